>>> design/expression_tokenizer_unit_defines.svh
// Assertion macros for the tokenizer modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef EXPRESSION_TOKENIZER_UNIT_DEFINES_SVH
`define EXPRESSION_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ETU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Next-cycle implication, disabled during reset
`define ETU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

>>> design/etu_pkg.sv
// Types, character codes and helpers for the expression tokenizer.
// No dependencies; used by every module of the block.
package etu_pkg;

   // Token kinds as they appear on the result channel
   typedef enum logic [3:0] {
      KIND_END    = 4'd0,
      KIND_NUM    = 4'd1,
      KIND_IDENT  = 4'd2,
      KIND_PLUS   = 4'd3,
      KIND_MINUS  = 4'd4,
      KIND_STAR   = 4'd5,
      KIND_SLASH  = 4'd6,
      KIND_CARET  = 4'd7,
      KIND_LPAREN = 4'd8,
      KIND_RPAREN = 4'd9,
      KIND_EQUALS = 4'd10,
      KIND_COMMA  = 4'd11
   } kind_type;

   // Scanner modes
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_NUM   = 2'd1,
      MODE_IDENT = 2'd2,
      MODE_HALT  = 2'd3
   } mode_type;

   localparam int unsigned VALUE_W = 63;
   localparam int unsigned FIELD_W = 12;
   localparam int unsigned SLOTS   = 3;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   // Character codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;

   // One result item, last-of-run flag is added at the output
   typedef struct packed {
      logic [FIELD_W-1:0] length;
      logic [FIELD_W-1:0] start;
      logic               ovf;
      logic [VALUE_W-1:0] value;
      kind_type           kind;
   } token_type;

   // Tokens caused by one character
   typedef struct packed {
      logic [1:0]                 count;
      token_type [SLOTS-1:0]      tok;
   } burst_type;

   // Single-character operator lookup, KIND_END when not an operator
   function automatic kind_type op_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CHAR_PLUS:   k = KIND_PLUS;
         CHAR_MINUS:  k = KIND_MINUS;
         CHAR_STAR:   k = KIND_STAR;
         CHAR_SLASH:  k = KIND_SLASH;
         CHAR_CARET:  k = KIND_CARET;
         CHAR_LPAREN: k = KIND_LPAREN;
         CHAR_RPAREN: k = KIND_RPAREN;
         CHAR_EQUALS: k = KIND_EQUALS;
         CHAR_COMMA:  k = KIND_COMMA;
         default:     k = KIND_END;
      endcase
      return k;
   endfunction

   // Implicit multiplication between prior token and the one starting now
   function automatic logic star_needed(input kind_type prior, input kind_type next);
      logic ends;
      ends = (prior == KIND_NUM) || (prior == KIND_IDENT) || (prior == KIND_RPAREN);
      return ends && !((prior == KIND_IDENT) && (next == KIND_LPAREN));
   endfunction

   function automatic token_type make_token(input kind_type kind,
                                            input logic [VALUE_W-1:0] value,
                                            input logic ovf,
                                            input logic [FIELD_W-1:0] start,
                                            input logic [FIELD_W-1:0] length);
      token_type t;
      t.kind   = kind;
      t.value  = value;
      t.ovf    = ovf;
      t.start  = start;
      t.length = length;
      return t;
   endfunction

endpackage

>>> design/etu_lexer.sv
// Scanner state and token generation for one character per cycle, advancing only when fire is high.
// Depends on etu_pkg.
module etu_lexer #(
   parameter int unsigned MAX_LEN = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,       // character taken this cycle
   input  logic [7:0]         char_code,
   output etu_pkg::burst_type lex_o
);

   localparam int unsigned PW = $clog2(MAX_LEN);

   etu_pkg::mode_type mode_ff, mode_in, start_mode;
   etu_pkg::kind_type pk_ff, pk_in;
   logic [etu_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic sat_ff, sat_in;
   logic [PW-1:0] start_ff, start_in, pos_ff, pos_in, pe_ff, pe_in;
   logic [PW-1:0] pos_next, len;
   logic [PW:0]   diff;
   logic [etu_pkg::VALUE_W+3:0] prod;
   logic [1:0] cnt;
   logic is_nul, is_digit, is_alpha, is_head, is_tail, is_blank;
   etu_pkg::kind_type opk;

   function automatic logic [etu_pkg::FIELD_W-1:0] to_field(input logic [PW-1:0] v);
      logic [PW+etu_pkg::FIELD_W-1:0] w;
      w = {{etu_pkg::FIELD_W{1'b0}}, v};
      return w[etu_pkg::FIELD_W-1:0];
   endfunction

   // Character classes
   assign is_nul   = (char_code == etu_pkg::CHAR_NUL);
   assign is_digit = (char_code >= etu_pkg::CHAR_ZERO) && (char_code <= etu_pkg::CHAR_NINE);
   assign is_alpha = ((char_code >= etu_pkg::CHAR_LOWER_A) && (char_code <= etu_pkg::CHAR_LOWER_Z))
                  || ((char_code >= etu_pkg::CHAR_UPPER_A) && (char_code <= etu_pkg::CHAR_UPPER_Z));
   assign is_head  = is_alpha || (char_code == etu_pkg::CHAR_UNDER);
   assign is_tail  = is_head || is_digit;
   assign is_blank = (char_code == etu_pkg::CHAR_SPACE)
                  || ((char_code >= etu_pkg::CHAR_TAB) && (char_code <= etu_pkg::CHAR_CR));
   assign opk      = etu_pkg::op_kind(char_code);

   // Offset arithmetic modulo MAX_LEN
   assign pos_next = (pos_ff == PW'(MAX_LEN - 1)) ? '0 : pos_ff + PW'(1);
   assign diff     = {1'b0, pos_ff} - {1'b0, start_ff};
   assign len      = diff[PW] ? PW'(diff + (PW+1)'(MAX_LEN)) : diff[PW-1:0];

   // acc * 10 + digit, saturation when the top bits are set
   assign prod = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0}
               + (etu_pkg::VALUE_W+4)'(char_code - etu_pkg::CHAR_ZERO);

   // Mode a fresh character opens from idle
   always_comb begin
      if (is_nul || is_blank) begin
         start_mode = etu_pkg::MODE_IDLE;
      end else if (is_digit) begin
         start_mode = etu_pkg::MODE_NUM;
      end else if (is_head) begin
         start_mode = etu_pkg::MODE_IDENT;
      end else if (opk != etu_pkg::KIND_END) begin
         start_mode = etu_pkg::MODE_IDLE;
      end else begin
         start_mode = etu_pkg::MODE_HALT;
      end
   end

   // Next mode
   always_comb begin
      unique case (mode_ff)
         etu_pkg::MODE_HALT:  mode_in = is_nul ? etu_pkg::MODE_IDLE : etu_pkg::MODE_HALT;
         etu_pkg::MODE_NUM:   mode_in = is_digit ? etu_pkg::MODE_NUM : start_mode;
         etu_pkg::MODE_IDENT: mode_in = is_tail ? etu_pkg::MODE_IDENT : start_mode;
         default:             mode_in = start_mode;
      endcase
   end

   // Tokens and datapath state
   always_comb begin
      lex_o    = '0;
      cnt      = 2'd0;
      pk_in    = pk_ff;
      pe_in    = pe_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      if (mode_ff == etu_pkg::MODE_HALT) begin
         if (is_nul) begin
            pk_in    = etu_pkg::KIND_END;
            pe_in    = '0;
            acc_in   = '0;
            sat_in   = 1'b0;
            start_in = '0;
            pos_in   = '0;
         end
      end else if ((mode_ff == etu_pkg::MODE_NUM) && is_digit) begin
         if (!sat_ff) begin
            if (prod[etu_pkg::VALUE_W+3:etu_pkg::VALUE_W] != 4'd0) begin
               acc_in = etu_pkg::VALUE_MAX;
               sat_in = 1'b1;
            end else begin
               acc_in = prod[etu_pkg::VALUE_W-1:0];
            end
         end
         pos_in = pos_next;
      end else if ((mode_ff == etu_pkg::MODE_IDENT) && is_tail) begin
         pos_in = pos_next;
      end else begin
         // close a pending multi-character token
         if (mode_ff == etu_pkg::MODE_NUM) begin
            lex_o.tok[cnt] = etu_pkg::make_token(etu_pkg::KIND_NUM, acc_ff, sat_ff,
                                                 to_field(start_ff), to_field(len));
            cnt   = cnt + 2'd1;
            pk_in = etu_pkg::KIND_NUM;
            pe_in = pos_ff;
         end else if (mode_ff == etu_pkg::MODE_IDENT) begin
            lex_o.tok[cnt] = etu_pkg::make_token(etu_pkg::KIND_IDENT, '0, 1'b0,
                                                 to_field(start_ff), to_field(len));
            cnt   = cnt + 2'd1;
            pk_in = etu_pkg::KIND_IDENT;
            pe_in = pos_ff;
         end
         if (is_nul) begin
            // end of expression
            lex_o.tok[cnt] = etu_pkg::make_token(etu_pkg::KIND_END, '0, 1'b0,
                                                 to_field(pos_ff), '0);
            cnt      = cnt + 2'd1;
            pk_in    = etu_pkg::KIND_END;
            pe_in    = '0;
            acc_in   = '0;
            sat_in   = 1'b0;
            start_in = '0;
            pos_in   = '0;
         end else begin
            if (is_blank) begin
               // skipped
            end else if (is_digit) begin
               if (etu_pkg::star_needed(pk_in, etu_pkg::KIND_NUM)) begin
                  lex_o.tok[cnt] = etu_pkg::make_token(etu_pkg::KIND_STAR, '0, 1'b0,
                                                       to_field(pe_in), '0);
                  cnt   = cnt + 2'd1;
                  pk_in = etu_pkg::KIND_STAR;
               end
               start_in = pos_ff;
               acc_in   = etu_pkg::VALUE_W'(char_code - etu_pkg::CHAR_ZERO);
               sat_in   = 1'b0;
            end else if (is_head) begin
               if (etu_pkg::star_needed(pk_in, etu_pkg::KIND_IDENT)) begin
                  lex_o.tok[cnt] = etu_pkg::make_token(etu_pkg::KIND_STAR, '0, 1'b0,
                                                       to_field(pe_in), '0);
                  cnt   = cnt + 2'd1;
                  pk_in = etu_pkg::KIND_STAR;
               end
               start_in = pos_ff;
            end else if (opk != etu_pkg::KIND_END) begin
               if ((opk == etu_pkg::KIND_LPAREN) &&
                   etu_pkg::star_needed(pk_in, etu_pkg::KIND_LPAREN)) begin
                  lex_o.tok[cnt] = etu_pkg::make_token(etu_pkg::KIND_STAR, '0, 1'b0,
                                                       to_field(pe_in), '0);
                  cnt = cnt + 2'd1;
               end
               lex_o.tok[cnt] = etu_pkg::make_token(opk, '0, 1'b0, to_field(pos_ff),
                                                    etu_pkg::FIELD_W'(1));
               cnt   = cnt + 2'd1;
               pk_in = opk;
               pe_in = pos_next;
            end else begin
               // unknown character: end token, then ignore until NUL
               lex_o.tok[cnt] = etu_pkg::make_token(etu_pkg::KIND_END, '0, 1'b0,
                                                    to_field(pos_ff), '0);
               cnt   = cnt + 2'd1;
               pk_in = etu_pkg::KIND_END;
               pe_in = pos_ff;
            end
            pos_in = pos_next;
         end
      end
      lex_o.count = cnt;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= etu_pkg::MODE_IDLE;
         pk_ff    <= etu_pkg::KIND_END;
         pe_ff    <= '0;
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
         start_ff <= '0;
         pos_ff   <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         pk_ff    <= pk_in;
         pe_ff    <= pe_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

>>> design/etu_burst.sv
// Result register: holds the tokens of one character and hands them out one per item.
// Depends on etu_pkg and the assertion macro header.
`include "expression_tokenizer_unit_defines.svh"

module etu_burst (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  etu_pkg::burst_type lex_i,
   output logic               free,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [87:0]        rsp_tdata,  // value[62:0], overflow, start[11:0], length[11:0]
   output logic [3:0]         rsp_tuser,  // token kind
   output logic               rsp_tlast
);

   etu_pkg::token_type [etu_pkg::SLOTS-1:0] tok_ff;
   logic [1:0] remain_ff, idx_ff;
   etu_pkg::token_type cur;
   logic take;

   assign cur        = tok_ff[idx_ff];
   assign rsp_tvalid = (remain_ff != 2'd0);
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = (remain_ff == 2'd0) || ((remain_ff == 2'd1) && rsp_tready);
   assign rsp_tdata  = {cur.length, cur.start, cur.ovf, cur.value};
   assign rsp_tuser  = cur.kind;
   assign rsp_tlast  = (remain_ff == 2'd1);

   // Token payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff <= lex_i.tok;
      end
   end

   // Drain counters
   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 2'd0;
         idx_ff    <= 2'd0;
      end else if (load) begin
         remain_ff <= lex_i.count;
         idx_ff    <= 2'd0;
      end else if (take) begin
         remain_ff <= remain_ff - 2'd1;
         idx_ff    <= idx_ff + 2'd1;
      end
   end

   `ETU_ASSERT_NOW(a_load_only_when_free, clock, reset, load, free && (lex_i.count != 2'd0))
   `ETU_ASSERT_NEXT(a_load_shows_item, clock, reset, load, rsp_tvalid && (idx_ff == 2'd0))
   `ETU_ASSERT_NEXT(a_take_advances, clock, reset, take && (remain_ff > 2'd1), idx_ff == ($past(idx_ff) + 2'd1))
   `ETU_ASSERT_NOW(a_index_in_range, clock, reset, rsp_tvalid, (3'(idx_ff) + 3'(remain_ff)) <= 3'd3)

endmodule

>>> design/expression_tokenizer_unit.sv
// Expression tokenizer: one character byte in per item, tokens out with offsets and lengths.
// Depends on etu_pkg, etu_lexer and etu_burst.
//
// The block takes one character per cycle into an input register and scans it in the next
// cycle; characters that only extend a number or identifier, or are blank, leave no result
// and never wait. A character that yields tokens waits until the result register is free,
// then loads up to three tokens (closing token, inserted star, new operator), which leave
// one per cycle unless stalled, so the rate is one item per cycle or one per token,
// whichever is slower, set by the single result port. Offsets count modulo MAX_LEN.
module expression_tokenizer_unit #(
   parameter int unsigned MAX_LEN = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // number_value[62:0], value_overflow, start_offset[11:0],
                                    // token_length[11:0]
   output logic [3:0]  rsp_tuser,   // token_kind[3:0]
   output logic        rsp_tlast    // last_of_run
);

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       move, load, free;
   etu_pkg::burst_type lex;

   // Character moves on when it has no token or the result register frees up
   assign move       = in_valid_ff && ((lex.count == 2'd0) || free);
   assign load       = move && (lex.count != 2'd0);
   assign req_tready = !in_valid_ff || move;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   etu_lexer #(
      .MAX_LEN (MAX_LEN)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .fire      (move),
      .char_code (in_char_ff),
      .lex_o     (lex)
   );

   etu_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .lex_i      (lex),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/expression_tokenizer_unit_test.sv
// Self-checking testbench for the expression tokenizer: streams characters in, checks tokens out.
// Depends on etu_pkg and expression_tokenizer_unit; expected tokens come from a local lexer model.
`timescale 1ns / 100ps

module expression_tokenizer_unit_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_CHARS = 12;
   localparam int TAIL_CHARS = 8;
   localparam logic [63:0] VALUE_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [7:0] OP_CHARS [9] = '{etu_pkg::CHAR_PLUS, etu_pkg::CHAR_MINUS,
      etu_pkg::CHAR_STAR, etu_pkg::CHAR_SLASH, etu_pkg::CHAR_CARET, etu_pkg::CHAR_LPAREN,
      etu_pkg::CHAR_RPAREN, etu_pkg::CHAR_EQUALS, etu_pkg::CHAR_COMMA};

   // One expected token as it should appear on the result channel
   typedef struct {
      etu_pkg::kind_type           kind;
      logic [etu_pkg::VALUE_W-1:0] value;
      logic                        ovf;
      logic [etu_pkg::FIELD_W-1:0] start;
      logic [etu_pkg::FIELD_W-1:0] length;
      logic                        last;
   } token_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;   // number_value[62:0], value_overflow, start_offset[11:0],
                             // token_length[11:0]
   logic [3:0]  rsp_tuser;   // token_kind[3:0]
   logic        rsp_tlast;   // last_of_run

   // Lexer model state
   etu_pkg::mode_type           lex_mode;
   logic [etu_pkg::VALUE_W-1:0] lex_value;
   logic                        lex_sat;
   logic [etu_pkg::FIELD_W-1:0] lex_start;
   logic [etu_pkg::FIELD_W-1:0] lex_pos;
   etu_pkg::kind_type           lex_prior;
   logic [etu_pkg::FIELD_W-1:0] lex_prior_end;

   token_rec_type char_tokens[$];
   token_rec_type expected_tokens[$];

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int hold_request = 0;
   int chars_sent = 0;
   int tokens_checked = 0;
   int mismatches = 0;
   int input_stalls = 0;
   int cycle_count = 0;

   expression_tokenizer_unit uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
                  expected_tokens.size());
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready) input_stalls++;
   end

   // ---------------------------------------------------------------- lexer model

   function automatic bit is_digit(input logic [7:0] c);
      return c >= etu_pkg::CHAR_ZERO && c <= etu_pkg::CHAR_NINE;
   endfunction

   function automatic bit is_head(input logic [7:0] c);
      return (c >= etu_pkg::CHAR_LOWER_A && c <= etu_pkg::CHAR_LOWER_Z) ||
             (c >= etu_pkg::CHAR_UPPER_A && c <= etu_pkg::CHAR_UPPER_Z) ||
             c == etu_pkg::CHAR_UNDER;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == etu_pkg::CHAR_SPACE || (c >= etu_pkg::CHAR_TAB && c <= etu_pkg::CHAR_CR);
   endfunction

   function automatic etu_pkg::kind_type operator_kind(input logic [7:0] c);
      case (c)
         etu_pkg::CHAR_PLUS:   return etu_pkg::KIND_PLUS;
         etu_pkg::CHAR_MINUS:  return etu_pkg::KIND_MINUS;
         etu_pkg::CHAR_STAR:   return etu_pkg::KIND_STAR;
         etu_pkg::CHAR_SLASH:  return etu_pkg::KIND_SLASH;
         etu_pkg::CHAR_CARET:  return etu_pkg::KIND_CARET;
         etu_pkg::CHAR_LPAREN: return etu_pkg::KIND_LPAREN;
         etu_pkg::CHAR_RPAREN: return etu_pkg::KIND_RPAREN;
         etu_pkg::CHAR_EQUALS: return etu_pkg::KIND_EQUALS;
         etu_pkg::CHAR_COMMA:  return etu_pkg::KIND_COMMA;
         default:              return etu_pkg::KIND_END;
      endcase
   endfunction

   task automatic clear_lexer();
      lex_mode = etu_pkg::MODE_IDLE;
      lex_value = '0;
      lex_sat = 1'b0;
      lex_start = '0;
      lex_pos = '0;
      lex_prior = etu_pkg::KIND_END;
      lex_prior_end = '0;
   endtask

   task automatic add_token(input etu_pkg::kind_type kind,
                            input logic [etu_pkg::VALUE_W-1:0] value,
                            input logic ovf, input logic [etu_pkg::FIELD_W-1:0] start,
                            input logic [etu_pkg::FIELD_W-1:0] length);
      token_rec_type t;
      t.kind = kind;
      t.value = value;
      t.ovf = ovf;
      t.start = start;
      t.length = length;
      t.last = 1'b0;
      char_tokens.push_back(t);
      lex_prior = kind;
      lex_prior_end = start + length;
   endtask

   // Zero-length star between an operand end and a following operand start
   task automatic add_implicit_star(input etu_pkg::kind_type next);
      if (!(lex_prior == etu_pkg::KIND_NUM || lex_prior == etu_pkg::KIND_IDENT ||
            lex_prior == etu_pkg::KIND_RPAREN))
         return;
      if (lex_prior == etu_pkg::KIND_IDENT && next == etu_pkg::KIND_LPAREN) return;
      add_token(etu_pkg::KIND_STAR, '0, 1'b0, lex_prior_end, '0);
   endtask

   // Tokens caused by one accepted character, appended to expected_tokens
   task automatic predict_tokens(input logic [7:0] c);
      logic [etu_pkg::FIELD_W-1:0] pos;
      logic [etu_pkg::FIELD_W-1:0] len;
      logic [63:0] digit;
      etu_pkg::kind_type k;
      pos = lex_pos;
      len = pos - lex_start;
      char_tokens.delete();

      // after an unknown character everything up to the terminator is dropped
      if (lex_mode == etu_pkg::MODE_HALT) begin
         if (c == etu_pkg::CHAR_NUL) clear_lexer();
         return;
      end

      // close or extend a pending number or identifier
      if (lex_mode == etu_pkg::MODE_NUM) begin
         if (is_digit(c)) begin
            digit = 64'(c - etu_pkg::CHAR_ZERO);
            if (!lex_sat) begin
               if ({1'b0, lex_value} > (VALUE_CEIL - digit) / 64'd10) begin
                  lex_value = etu_pkg::VALUE_MAX;
                  lex_sat = 1'b1;
               end else begin
                  lex_value = etu_pkg::VALUE_W'({1'b0, lex_value} * 64'd10 + digit);
               end
            end
            lex_pos = pos + 1'b1;
            return;
         end
         add_token(etu_pkg::KIND_NUM, lex_value, lex_sat, lex_start, len);
         lex_mode = etu_pkg::MODE_IDLE;
      end else if (lex_mode == etu_pkg::MODE_IDENT) begin
         if (is_head(c) || is_digit(c)) begin
            lex_pos = pos + 1'b1;
            return;
         end
         add_token(etu_pkg::KIND_IDENT, '0, 1'b0, lex_start, len);
         lex_mode = etu_pkg::MODE_IDLE;
      end

      // start of something new
      if (c == etu_pkg::CHAR_NUL) begin
         add_token(etu_pkg::KIND_END, '0, 1'b0, pos, '0);
         clear_lexer();
      end else begin
         if (is_blank(c)) begin
            // skipped
         end else if (is_digit(c)) begin
            add_implicit_star(etu_pkg::KIND_NUM);
            lex_mode = etu_pkg::MODE_NUM;
            lex_start = pos;
            lex_value = etu_pkg::VALUE_W'(c - etu_pkg::CHAR_ZERO);
            lex_sat = 1'b0;
         end else if (is_head(c)) begin
            add_implicit_star(etu_pkg::KIND_IDENT);
            lex_mode = etu_pkg::MODE_IDENT;
            lex_start = pos;
         end else begin
            k = operator_kind(c);
            if (k != etu_pkg::KIND_END) begin
               if (k == etu_pkg::KIND_LPAREN) add_implicit_star(k);
               add_token(k, '0, 1'b0, pos, 12'd1);
            end else begin
               add_token(etu_pkg::KIND_END, '0, 1'b0, pos, '0);
               lex_mode = etu_pkg::MODE_HALT;
            end
         end
         lex_pos = pos + 1'b1;
      end

      if (char_tokens.size() > 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
      foreach (char_tokens[i]) expected_tokens.push_back(char_tokens[i]);
   endtask

   // ---------------------------------------------------------------- result side

   function automatic void check_field(input string name,
                                       input logic [etu_pkg::VALUE_W-1:0] want,
                                       input logic [etu_pkg::VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : token_check
      token_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            $error("unexpected token: kind %0d start %0d", rsp_tuser, rsp_tdata[75:64]);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", want.kind, rsp_tuser);
            check_field("number_value", want.value, rsp_tdata[62:0]);
            check_field("value_overflow", want.ovf, rsp_tdata[63]);
            check_field("start_offset", want.start, rsp_tdata[75:64]);
            check_field("token_length", want.length, rsp_tdata[87:76]);
            check_field("last_of_run", want.last, rsp_tlast);
            tokens_checked++;
         end
      end
   end

   // Receiver: random stall bursts, plus long hold-offs on request
   initial begin : token_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 8) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- input side

   task automatic idle_input(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offer one character and wait until it is taken
   task automatic send_char(input logic [7:0] c);
      if (req_idle_on && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 8));
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      predict_tokens(c);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic logic [7:0] random_head();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return etu_pkg::CHAR_LOWER_A + 8'(r);
      if (r < 52) return etu_pkg::CHAR_UPPER_A + 8'(r - 26);
      return etu_pkg::CHAR_UNDER;
   endfunction

   function automatic logic [7:0] random_tail();
      if ($urandom_range(0, 4) == 0) return etu_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      return random_head();
   endfunction

   // Mostly well-formed expression; some carry a stray byte anywhere
   task automatic send_random_expression();
      int pieces;
      int n;
      bit noisy;
      pieces = $urandom_range(1, 8);
      noisy = ($urandom_range(0, 5) == 0);
      for (int p = 0; p < pieces; p++) begin
         if (noisy && $urandom_range(0, 3) == 0) send_char(8'($urandom_range(1, 255)));
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               n = ($urandom_range(0, 12) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 3);
               repeat (n) send_char(etu_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            3, 4: begin
               send_char(random_head());
               repeat ($urandom_range(0, 3)) send_char(random_tail());
            end
            5, 6, 7: send_char(OP_CHARS[$urandom_range(0, 8)]);
            8: send_char($urandom_range(0, 1) ? etu_pkg::CHAR_SPACE :
                         8'($urandom_range(9, 13)));
            default: send_char($urandom_range(0, 1) ? etu_pkg::CHAR_LPAREN :
                               etu_pkg::CHAR_RPAREN);
         endcase
      end
      send_char(etu_pkg::CHAR_NUL);
   endtask

   // ---------------------------------------------------------------- tests

   // Every operator, identifier chars, every blank, terminator
   task automatic test_operators_and_blanks();
      send_text("(x1_)+-*/^=,");
      for (int c = etu_pkg::CHAR_TAB; c <= etu_pkg::CHAR_CR; c++) send_char(8'(c));
      send_char(etu_pkg::CHAR_SPACE);
      send_char(etu_pkg::CHAR_NUL);
   endtask

   // Implicit multiplication after numbers, identifiers and closing parentheses, and where it must not appear
   task automatic test_implicit_star();
      send_text("2x 3(y)4 _z(1)(2)0 a b)Q");
      send_char(etu_pkg::CHAR_NUL);
   endtask

   // Largest value, one past it, and a digit after saturation
   task automatic test_number_limits();
      send_text("9223372036854775807 92233720368547758089");
      send_char(etu_pkg::CHAR_NUL);
   endtask

   // Unknown byte closes the expression; the rest is dropped until the terminator
   task automatic test_unknown_char();
      send_text("ab!12(xyz");
      send_char(8'hFF);
      send_char(8'h80);
      send_char(etu_pkg::CHAR_NUL);
      send_text("q");
      send_char(etu_pkg::CHAR_NUL);
      send_char(8'hFF);
      send_char(etu_pkg::CHAR_NUL);
   endtask

   // Receiver holds off while the sender keeps offering token-producing chars
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      hold_request = 200;
      send_text("+-)(*/^=,");
      send_char(etu_pkg::CHAR_NUL);
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_expressions(input int count);
      int first;
      first = chars_sent;
      while (chars_sent - first < count) send_random_expression();
   endtask

   initial begin
      clear_lexer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_operators_and_blanks();
      test_implicit_star();
      test_number_limits();
      test_unknown_char();
      test_backpressure();
      test_random_expressions(RANDOM_CHARS);

      // closing stretch with both sides at full rate
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_expressions(TAIL_CHARS);

      idle_input(1);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d characters (operators, blanks, implicit star, saturation, stray bytes);",
               chars_sent);
      $display("checked %0d tokens, input held back for %0d cycles.", tokens_checked,
               input_stalls);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
